// ----- rtl/core/lcl_pkg.sv -----
// shared types and constants for the lfu cache with lru tie-break
// no dependencies; used by lcl_cmp, lcl_store and lfu_cache_lru_tiebreak_top
package lcl_pkg;

	localparam int ENTRIES_DEF = 16;
	localparam int CAP_W       = 5;
	localparam int DATA_W      = 32;
	localparam int COUNT_W     = 16;

	localparam logic [CAP_W-1:0]   CAP_RESET  = CAP_W'(16);
	localparam logic [DATA_W-1:0]  READ_MISS  = '1;
	localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
	localparam logic [COUNT_W-1:0] COUNT_INIT = COUNT_W'(1);

	localparam logic REQ_GET = 1'b0;
	localparam logic REQ_PUT = 1'b1;

	typedef struct packed {
		logic                     req_type;
		logic signed [DATA_W-1:0] key;
		logic signed [DATA_W-1:0] write_value;
	} req_t;

	typedef struct packed {
		logic                     found;
		logic signed [DATA_W-1:0] read_value;
		logic                     evicted;
		logic signed [DATA_W-1:0] evicted_key;
	} rsp_t;

	typedef struct packed {
		logic [DATA_W-1:0]  key;
		logic [DATA_W-1:0]  value;
		logic [COUNT_W-1:0] count;
		logic [DATA_W-1:0]  stamp;
	} entry_t;

	typedef struct packed {
		logic              key_eq;
		logic              better;
		logic [DATA_W-1:0] age;
	} cmp_t;

endpackage

// ----- rtl/core/lcl_cmp.sv -----
// shared compare unit: key match and victim ranking for one entry per cycle
// depends on lcl_pkg
module lcl_cmp (
	input  lcl_pkg::entry_t                   ent,
	input  logic [lcl_pkg::DATA_W-1:0]        key,
	input  logic [lcl_pkg::DATA_W-1:0]        time_now,
	input  logic                              any,
	input  logic [lcl_pkg::COUNT_W-1:0]       best_cnt,
	input  logic [lcl_pkg::DATA_W-1:0]        best_age,
	output lcl_pkg::cmp_t                     res
);

	logic [lcl_pkg::DATA_W-1:0] age;

	// age wraps with the stamp, so the modular difference ranks correctly
	assign age        = time_now - ent.stamp;
	assign res.age    = age;
	assign res.key_eq = (ent.key == key);
	assign res.better = !any || (ent.count < best_cnt) ||
		((ent.count == best_cnt) && (age > best_age));

endmodule

// ----- rtl/core/lcl_store.sv -----
// entry store: key, value, use count and stamp, one write and one read port
// depends on lcl_pkg
module lcl_store #(
	parameter int ENTRIES = lcl_pkg::ENTRIES_DEF
) (
	input  logic                                              clk,
	input  logic                                              wr_en,
	input  logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0]    wr_addr,
	input  lcl_pkg::entry_t                                   wr_data,
	input  logic                                              rd_en,
	input  logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0]    rd_addr,
	output lcl_pkg::entry_t                                   rd_data
);

	lcl_pkg::entry_t mem_q [ENTRIES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ----- rtl/core/lfu_cache_lru_tiebreak_top.sv -----
// top level of the lfu cache with lru tie-break: sequencer, valid bits, results
// depends on lcl_pkg, lcl_store and lcl_cmp
//
// usage
//   req channel (req_valid / req_ready / req): one get or put per transfer
//   rsp channel (rsp_valid / rsp_ready / rsp): exactly one result per request
//   cfg_we / cfg_wdata: writes capacity_in_use, only while the block is idle
// timing
//   a request walks every slot of the entry store through its single read
//   port, one slot a cycle, with the shared compare unit checking the key and
//   ranking the slot as eviction candidate in the same step
//   after the scan the sequencer steps through its wait, decide and out states,
//   and the result is registered in the rsp register before rsp_valid rises
//   req_ready is high only while the sequencer is idle
// reset
//   arst_n clears the valid bits, the time stamp and the sequencer, and sets
//   capacity_in_use to 16; entry contents are left as they are
// stalls
//   a finished result sits in the rsp register until taken; the next request
//   is still accepted and worked on, and waits at the end for the register
module lfu_cache_lru_tiebreak_top #(
	parameter int ENTRIES = lcl_pkg::ENTRIES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [lcl_pkg::CAP_W-1:0]     cfg_wdata,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  lcl_pkg::req_t                 req,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output lcl_pkg::rsp_t                 rsp
);

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int UW = $clog2(ENTRIES + 1);
	localparam int CW = (UW > lcl_pkg::CAP_W) ? UW : lcl_pkg::CAP_W;

	// sequencer codes
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCAN   = 3'd1;
	localparam logic [2:0] ST_WAIT   = 3'd2;
	localparam logic [2:0] ST_DECIDE = 3'd3;
	localparam logic [2:0] ST_OUT    = 3'd4;

	logic [2:0]                       state_q;
	logic [lcl_pkg::CAP_W-1:0]        cap_q;
	logic [lcl_pkg::DATA_W-1:0]       time_now_q;
	logic [ENTRIES-1:0]               valid_q;
	lcl_pkg::req_t                    req_q;
	logic [IW-1:0]                    idx_q;

	// compare stage, in the cycle after the read address
	logic                             vld_s1;
	logic [IW-1:0]                    idx_s1;

	// scan results
	logic                             hit_q;
	logic [IW-1:0]                    hit_slot_q;
	logic [lcl_pkg::DATA_W-1:0]       hit_val_q;
	logic [lcl_pkg::COUNT_W-1:0]      hit_cnt_q;
	logic                             have_free_q;
	logic [IW-1:0]                    free_slot_q;
	logic [UW-1:0]                    used_q;
	logic                             any_q;
	logic [IW-1:0]                    best_slot_q;
	logic [lcl_pkg::COUNT_W-1:0]      best_cnt_q;
	logic [lcl_pkg::DATA_W-1:0]       best_age_q;
	logic [lcl_pkg::DATA_W-1:0]       best_key_q;

	lcl_pkg::rsp_t                    res_q;
	logic                             rsp_valid_q;
	lcl_pkg::rsp_t                    rsp_q;

	lcl_pkg::entry_t                  rd_data;
	lcl_pkg::entry_t                  wr_data;
	lcl_pkg::cmp_t                    cmp_res;
	logic                             rd_en;
	logic                             wr_en;
	logic [IW-1:0]                    wr_addr;
	logic                             ent_valid;

	// decision signals
	logic [CW-1:0]                    cap_eff;
	logic                             room;
	logic                             is_put;
	logic                             evict;
	logic [lcl_pkg::COUNT_W-1:0]      hit_cnt_next;
	lcl_pkg::rsp_t                    res_next;

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign rd_en     = (state_q == ST_SCAN);
	assign ent_valid = valid_q[idx_s1];

	lcl_store #(
		.ENTRIES (ENTRIES)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (idx_q),
		.rd_data (rd_data)
	);

	lcl_cmp u_cmp (
		.ent      (rd_data),
		.key      (req_q.key),
		.time_now (time_now_q),
		.any      (any_q),
		.best_cnt (best_cnt_q),
		.best_age (best_age_q),
		.res      (cmp_res)
	);

	// capacity saturates at the number of slots built
	always_comb begin
		cap_eff = CW'(cap_q);
		if (cap_eff > CW'(ENTRIES)) begin
			cap_eff = CW'(ENTRIES);
		end
	end

	assign is_put       = (req_q.req_type == lcl_pkg::REQ_PUT);
	assign room         = (CW'(used_q) < cap_eff) && have_free_q;
	assign evict        = is_put && (cap_eff != '0) && !hit_q && !room && any_q;
	assign hit_cnt_next = (hit_cnt_q == lcl_pkg::COUNT_MAX) ? hit_cnt_q
		: hit_cnt_q + lcl_pkg::COUNT_W'(1);

	// at most one write per request: a get hit restamps, a put hit or miss stores unless capacity is zero
	always_comb begin
		wr_en = 1'b0;
		if (state_q == ST_DECIDE) begin
			wr_en = is_put ? (cap_eff != '0) : hit_q;
		end
	end

	always_comb begin
		priority if (hit_q) begin
			wr_addr = hit_slot_q;
		end else if (room) begin
			wr_addr = free_slot_q;
		end else begin
			wr_addr = best_slot_q;
		end
	end

	assign wr_data.key   = req_q.key;
	assign wr_data.value = is_put ? req_q.write_value : hit_val_q;
	assign wr_data.count = hit_q ? hit_cnt_next : lcl_pkg::COUNT_INIT;
	assign wr_data.stamp = time_now_q;

	always_comb begin
		res_next.found       = hit_q;
		res_next.evicted     = evict;
		res_next.evicted_key = evict ? best_key_q : '0;
		priority if (is_put) begin
			res_next.read_value = '0;
		end else if (hit_q) begin
			res_next.read_value = hit_val_q;
		end else begin
			res_next.read_value = lcl_pkg::READ_MISS;
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= lcl_pkg::CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// sequencer and scan bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			time_now_q <= '0;
			valid_q    <= '0;
			idx_q      <= '0;
			vld_s1     <= 1'b0;
		end else begin
			vld_s1 <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						time_now_q <= time_now_q + lcl_pkg::DATA_W'(1);
						idx_q      <= '0;
						state_q    <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// issue one slot read a cycle
					vld_s1 <= 1'b1;
					if (idx_q == IW'(ENTRIES - 1)) begin
						state_q <= ST_WAIT;
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end
				ST_WAIT: begin
					// last slot is compared in this cycle
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (wr_en) begin
						valid_q[wr_addr] <= 1'b1;
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!rsp_valid_q || rsp_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// scan accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q       <= 1'b0;
			have_free_q <= 1'b0;
			any_q       <= 1'b0;
			used_q      <= '0;
		end else if (req_valid && req_ready) begin
			hit_q       <= 1'b0;
			have_free_q <= 1'b0;
			any_q       <= 1'b0;
			used_q      <= '0;
		end else if (vld_s1) begin
			if (ent_valid) begin
				used_q <= used_q + UW'(1);
				if (!hit_q && cmp_res.key_eq) begin
					hit_q <= 1'b1;
				end
				if (cmp_res.better) begin
					any_q <= 1'b1;
				end
			end else if (!have_free_q) begin
				have_free_q <= 1'b1;
			end
		end
	end

	// scan payload, no reset needed
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_q <= req;
		end
		if (state_q == ST_SCAN) begin
			idx_s1 <= idx_q;
		end
		if (vld_s1) begin
			if (ent_valid) begin
				if (!hit_q && cmp_res.key_eq) begin
					hit_slot_q <= idx_s1;
					hit_val_q  <= rd_data.value;
					hit_cnt_q  <= rd_data.count;
				end
				if (cmp_res.better) begin
					best_slot_q <= idx_s1;
					best_cnt_q  <= rd_data.count;
					best_age_q  <= cmp_res.age;
					best_key_q  <= rd_data.key;
				end
			end else if (!have_free_q) begin
				free_slot_q <= idx_s1;
			end
		end
		if (state_q == ST_DECIDE) begin
			res_q <= res_next;
		end
		if ((state_q == ST_OUT) && (!rsp_valid_q || rsp_ready)) begin
			rsp_q <= res_q;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if ((state_q == ST_OUT) && (!rsp_valid_q || rsp_ready)) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// every request advances the time stamp by one
	a_time_step: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> (time_now_q == $past(time_now_q) + 32'd1))
		else $error("time stamp did not advance on request transfer");

	// slots are never released
	a_valid_grow: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> ($countones(valid_q) >= $countones($past(valid_q))))
		else $error("valid entry count dropped");

	// an eviction reuses a slot, so the valid count holds
	a_evict_reuse: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_DECIDE) && evict) |=>
		($countones(valid_q) == $countones($past(valid_q))))
		else $error("eviction changed the valid entry count");

	// an eviction only follows a put miss
	a_evict_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.evicted) |-> !rsp_q.found)
		else $error("eviction reported on a hit");

	// store is written only when the decision is taken
	a_write_slot: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == ST_DECIDE) && (!hit_q || valid_q[wr_addr]))
		else $error("store write outside decision or hit slot not valid");

endmodule
